// File: hw/rtl/prle_pkg.sv
package prle_pkg;

    localparam int unsigned MAX_LITERAL = 32;
    localparam int unsigned BYTE_W      = 8;
    // Fill level of the literal store runs from 0 to MAX_LITERAL inclusive.
    localparam int unsigned LIT_CNT_W   = $clog2(MAX_LITERAL + 1);
    localparam int unsigned LIT_AW      = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

    localparam logic [BYTE_W-1:0]    RUN_HDR_MAX   = 8'd127;
    localparam logic [BYTE_W-1:0]    HDR_ONE_LIT   = 8'hFF;
    localparam logic [BYTE_W-1:0]    HDR_ONE_COPY  = 8'h00;
    localparam logic [LIT_CNT_W-1:0] LIT_LAST_SLOT = LIT_CNT_W'(MAX_LITERAL - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_RUN_HDR,
        S_RUN_SYM,
        S_CLOSE,
        S_LONE_SYM,
        S_LIT,
        S_EOS,
        S_EOS_SYM
    } t_state;

    typedef enum logic [2:0] {
        SEL_RUN_HDR,
        SEL_EOS_HDR,
        SEL_LIT_HDR,
        SEL_ZERO,
        SEL_PEND,
        SEL_CUR,
        SEL_LIT0,
        SEL_LIT_RD
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     first;
        logic     cnt_inc;
        logic     store;
        logic     store_cur;
        logic     run_done;
        logic     close_done;
        logic     lone_done;
        logic     clear;
        logic     advance;
        logic     emit;
        t_out_sel sel;
        logic     last;
        logic     lit_start;
        logic     lit_next;
    } t_cmd;

    typedef struct packed {
        logic have_pending;
        logic same;
        logic lit_none;
        logic cnt_neg;
        logic cnt_zero;
        logic cnt_top;
        logic lit_last_slot;
        logic lone_match;
        logic lit_final;
        logic eos;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/prle_if.sv
interface prle_in_if;
    import prle_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface prle_out_if;
    import prle_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: hw/rtl/prle_ctrl.sv
module prle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  prle_pkg::t_status i_status,
    output prle_pkg::t_cmd    o_cmd
);
    import prle_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_phase_b;
    logic   n_phase_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase_b <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase_b <= n_phase_b;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_phase_b = r_phase_b;
        o_cmd     = '0;
        o_cmd.sel = SEL_ZERO;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end

            S_EVAL: begin
                if (!i_status.have_pending) begin
                    o_cmd.first   = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state       = i_status.eos ? S_EOS : S_IDLE;
                    n_phase_b     = i_status.eos;
                end else if (i_status.same) begin
                    if (i_status.lit_none && !i_status.cnt_neg) begin
                        if (!i_status.cnt_top) begin
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.advance = 1'b1;
                            n_state       = i_status.eos ? S_EOS : S_IDLE;
                            n_phase_b     = i_status.eos;
                        end else begin
                            n_state = S_RUN_HDR;
                        end
                    end else begin
                        n_state = S_CLOSE;
                    end
                end else if (i_status.lit_none && !i_status.cnt_neg && !i_status.cnt_zero) begin
                    n_state = S_RUN_HDR;
                end else begin
                    o_cmd.store = 1'b1;
                    if (i_status.lit_last_slot) begin
                        n_state = S_CLOSE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = i_status.eos ? S_EOS : S_IDLE;
                        n_phase_b     = i_status.eos;
                    end
                end
            end

            S_RUN_HDR: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_RUN_HDR;
                    n_state    = S_RUN_SYM;
                end
            end

            S_RUN_SYM: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel      = SEL_PEND;
                    o_cmd.last     = !i_status.eos;
                    o_cmd.run_done = 1'b1;
                    o_cmd.advance  = 1'b1;
                    n_state        = i_status.eos ? S_EOS : S_IDLE;
                    n_phase_b      = i_status.eos;
                end
            end

            S_CLOSE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.lone_match) begin
                        o_cmd.sel = SEL_ZERO;
                        n_state   = S_LONE_SYM;
                    end else begin
                        o_cmd.sel       = SEL_LIT_HDR;
                        o_cmd.lit_start = 1'b1;
                        n_state         = S_LIT;
                    end
                end
            end

            S_LONE_SYM: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LIT0;
                    o_cmd.last = !r_phase_b && !i_status.eos;
                    if (r_phase_b) begin
                        // The final byte still follows as a one-literal block.
                        o_cmd.lone_done = 1'b1;
                        n_state         = S_EOS;
                    end else begin
                        o_cmd.close_done = 1'b1;
                        o_cmd.advance    = 1'b1;
                        n_state          = i_status.eos ? S_EOS : S_IDLE;
                        n_phase_b        = i_status.eos;
                    end
                end
            end

            S_LIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel      = SEL_LIT_RD;
                    o_cmd.lit_next = 1'b1;
                    o_cmd.last     = i_status.lit_final && (r_phase_b || !i_status.eos);
                    if (i_status.lit_final) begin
                        if (r_phase_b) begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_IDLE;
                            n_phase_b   = 1'b0;
                        end else begin
                            o_cmd.close_done = 1'b1;
                            o_cmd.advance    = 1'b1;
                            n_state          = i_status.eos ? S_EOS : S_IDLE;
                            n_phase_b        = i_status.eos;
                        end
                    end
                end
            end

            S_EOS: begin
                if (i_status.lit_none) begin
                    if (i_status.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = SEL_EOS_HDR;
                        n_state    = S_EOS_SYM;
                    end
                end else if (i_status.lone_match) begin
                    n_state = S_CLOSE;
                end else begin
                    // The final byte joins the buffered literals.
                    o_cmd.store     = 1'b1;
                    o_cmd.store_cur = 1'b1;
                    n_state         = S_CLOSE;
                end
            end

            S_EOS_SYM: begin
                if (i_status.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.sel   = SEL_CUR;
                    o_cmd.last  = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                    n_phase_b   = 1'b0;
                end
            end

            default: begin
                n_state   = S_IDLE;
                n_phase_b = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/prle_dpath.sv
module prle_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [prle_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_end_of_stream,
    input  logic                        i_out_ready,
    input  prle_pkg::t_cmd              i_cmd,
    output prle_pkg::t_status           o_status,
    output logic                        o_out_valid,
    output logic [prle_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_out_last
);
    import prle_pkg::*;

    logic [BYTE_W-1:0] r_lit_mem [MAX_LITERAL];

    logic                 r_have_pending, n_have_pending;
    logic [BYTE_W-1:0]    r_pend, n_pend;
    logic [BYTE_W-1:0]    r_cnt, n_cnt;
    logic [LIT_CNT_W-1:0] r_lc, n_lc;
    logic                 r_rje, n_rje;
    logic [BYTE_W-1:0]    r_ers, n_ers;
    logic [LIT_CNT_W-1:0] r_idx, n_idx;
    logic                 r_out_valid;

    logic [BYTE_W-1:0]    r_cur;
    logic                 r_eos;
    logic [BYTE_W-1:0]    r_lit0, n_lit0;
    logic [BYTE_W-1:0]    r_rd_data;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_last;

    logic [BYTE_W-1:0]    w_store_val;
    logic [LIT_CNT_W-1:0] w_lc_inc;
    logic                 w_same;
    logic                 w_lit_final;
    logic                 w_rd_en;
    logic [LIT_AW-1:0]    w_rd_addr;
    logic [BYTE_W-1:0]    w_out_mux;

    assign w_store_val = i_cmd.store_cur ? r_cur : r_pend;
    assign w_lc_inc    = r_lc + 1'b1;
    assign w_same      = (r_cur == r_pend);
    assign w_lit_final = (r_idx == r_lc);

    always_comb begin
        n_have_pending = r_have_pending;
        n_pend         = r_pend;
        n_cnt          = r_cnt;
        n_lc           = r_lc;
        n_rje          = r_rje;
        n_ers          = r_ers;
        n_idx          = r_idx;
        n_lit0         = r_lit0;

        if (i_cmd.first) begin
            n_have_pending = 1'b1;
            n_cnt          = '0;
            n_lc           = '0;
        end
        if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.store) begin
            n_lc  = w_lc_inc;
            // The count register holds the literal total as a negative number.
            n_cnt = 8'h00 - BYTE_W'(w_lc_inc);
            if (r_lc == '0) begin
                n_lit0 = w_store_val;
            end
        end
        if (i_cmd.run_done) begin
            n_cnt = '0;
            n_rje = 1'b1;
            n_ers = r_pend;
        end
        if (i_cmd.close_done) begin
            n_lc  = '0;
            n_cnt = w_same ? 8'd1 : 8'd0;
            n_rje = 1'b0;
        end
        if (i_cmd.lone_done) begin
            n_lc  = '0;
            n_cnt = '0;
        end
        if (i_cmd.advance) begin
            n_pend = r_cur;
        end
        if (i_cmd.lit_start) begin
            n_idx = LIT_CNT_W'(1);
        end else if (i_cmd.lit_next) begin
            n_idx = r_idx + 1'b1;
        end
        if (i_cmd.clear) begin
            n_have_pending = 1'b0;
            n_pend         = '0;
            n_cnt          = '0;
            n_lc           = '0;
            n_rje          = 1'b0;
            n_ers          = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_pending <= 1'b0;
            r_pend         <= '0;
            r_cnt          <= '0;
            r_lc           <= '0;
            r_rje          <= 1'b0;
            r_ers          <= '0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_have_pending <= n_have_pending;
            r_pend         <= n_pend;
            r_cnt          <= n_cnt;
            r_lc           <= n_lc;
            r_rje          <= n_rje;
            r_ers          <= n_ers;
            r_idx          <= n_idx;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lit0 <= n_lit0;
        if (i_cmd.load) begin
            r_cur <= i_data_byte;
            r_eos <= i_end_of_stream;
        end
        if (i_cmd.emit) begin
            r_out_byte <= w_out_mux;
            r_out_last <= i_cmd.last;
        end
    end

    // Literals are read one beat ahead; the read only moves when a beat is sent.
    assign w_rd_en   = i_cmd.lit_start || (i_cmd.lit_next && !w_lit_final);
    assign w_rd_addr = i_cmd.lit_start ? '0 : r_idx[LIT_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_lit_mem[r_lc[LIT_AW-1:0]] <= w_store_val;
        end
        if (w_rd_en) begin
            r_rd_data <= r_lit_mem[w_rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_RUN_HDR: w_out_mux = r_cnt;
            SEL_EOS_HDR: w_out_mux = (r_cnt != '0) ? r_cnt : HDR_ONE_LIT;
            SEL_LIT_HDR: w_out_mux = 8'h00 - BYTE_W'(r_lc);
            SEL_ZERO:    w_out_mux = HDR_ONE_COPY;
            SEL_PEND:    w_out_mux = r_pend;
            SEL_CUR:     w_out_mux = r_cur;
            SEL_LIT0:    w_out_mux = r_lit0;
            SEL_LIT_RD:  w_out_mux = r_rd_data;
            default:     w_out_mux = HDR_ONE_COPY;
        endcase
    end

    assign o_status.have_pending  = r_have_pending;
    assign o_status.same          = w_same;
    assign o_status.lit_none      = (r_lc == '0);
    assign o_status.cnt_neg       = r_cnt[BYTE_W-1];
    assign o_status.cnt_zero      = (r_cnt == '0);
    assign o_status.cnt_top       = (r_cnt == RUN_HDR_MAX);
    assign o_status.lit_last_slot = (r_lc == LIT_LAST_SLOT);
    assign o_status.lone_match    = (r_lc == LIT_CNT_W'(1)) && r_rje && (r_ers == r_lit0);
    assign o_status.lit_final     = w_lit_final;
    assign o_status.eos           = r_eos;
    assign o_status.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// File: hw/rtl/packbits_style_rle_encoder.sv
// Channel   Direction  Payload                           Beat taken when
// i_in      sink       data_byte[7:0], end_of_stream     i_in.valid && i_in.ready
// o_out     source     out_byte[7:0], last               o_out.valid && o_out.ready
//
// One byte is worked on at a time: i_in.ready is high only while the sequencer is idle.
// A byte that causes no output passes through a load and an evaluate step, and each encoded
// byte adds an emit step while o_out is ready; a final byte that meets buffered literals adds
// a store step, so the longest item is a full literal flush that ends the stream.
// A stall on o_out holds the sequencer in its current emit step; nothing is dropped.
// Synchronous active-low reset returns the encoder to the start of a stream.
module packbits_style_rle_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prle_in_if.sink     i_in,
    prle_out_if.source  o_out
);
    import prle_pkg::*;

    t_cmd              w_cmd;
    t_status           w_status;
    logic              w_in_ready;
    logic              w_out_valid;
    logic [BYTE_W-1:0] w_out_byte;
    logic              w_out_last;

    prle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    prle_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_data_byte     (i_in.data_byte),
        .i_end_of_stream (i_in.end_of_stream),
        .i_out_ready     (o_out.ready),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (w_out_valid),
        .o_out_byte      (w_out_byte),
        .o_out_last      (w_out_last)
    );

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = w_out_valid;
    assign o_out.out_byte = w_out_byte;
    assign o_out.last     = w_out_last;

endmodule
